@@ sv/hequ_pkg.sv @@
// Shared constants and types for the H-equation residual block.
package hequ_pkg;

  localparam int MAX_POINTS = 64;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNT_W      = AW + 1;
  localparam int N_W        = 7;
  localparam int OM_W       = 17;
  localparam int X_W        = 32;
  localparam int K_W        = 7;
  localparam int TQ_W       = 41;
  localparam int S_W        = 49;
  localparam int DVD_W      = 53;
  localparam int DVS_W      = 48;
  localparam int NORM_W     = 64;
  localparam int ROOT_W     = 32;
  localparam int TDATA_OUT_W = 72;

  localparam logic [OM_W-1:0] OM_ONE = 17'd65536;

  localparam logic CFG_POINTS = 1'b0;
  localparam logic CFG_ALBEDO = 1'b1;

  typedef struct packed {
    logic [N_W-1:0]  n;
    logic [OM_W-1:0] om;
  } run_cmd_t;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [TQ_W-1:0] mag;
    logic [K_W-1:0]  k;
  } term_req_t;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic [TQ_W-1:0] quo;
  } term_rsp_t;

endpackage

@@ sv/h_equation_residual.sv @@
// Top level of the H-equation residual block.
//
// Samples x_j arrive as words on the s_t* channel (signed Q8.24) in index
// order. Once points_used samples are in, the block computes the residual
// g_i = x_i - 1/(1 - s_i) for every i and sends one word per element on the
// m_t* channel; m_tlast marks the final element, which also carries the
// Euclidean norm of g. A sample that does not complete a load gives no word.
// Each element issues n terms, drains the 41-stage term divider and runs a
// serial division, then a second one unless the denominator is zero; the last
// element also takes a square root. The input is held off (s_tready low)
// from the word that completes a load until the cycle after the last result
// is in the output register.
// The output register lets a finished result wait while the next element is
// computed; when the receiver stalls, the sequencer waits in front of it.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written while idle;
// the block itself does not enforce this.
// Reset is synchronous: counts clear, points_used returns to 64 and albedo to
// 58982; the iterate store is not cleared.
module h_equation_residual (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [31:0]                        s_tdata,   // x_value[31:0]
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // residual[31:0], element_index[37:32], residual_norm[69:38], zero pad
  output logic [hequ_pkg::TDATA_OUT_W-1:0]   m_tdata,
  output logic                               m_tuser,   // singular[0]
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [hequ_pkg::OM_W-1:0]          cfg_data
);

  logic [hequ_pkg::N_W-1:0]      points_used;
  logic [hequ_pkg::OM_W-1:0]     albedo;
  logic                          ram_we;
  logic [hequ_pkg::AW-1:0]       ram_waddr;
  logic [hequ_pkg::X_W-1:0]      ram_wdata;
  logic                          ram_re;
  logic [hequ_pkg::AW-1:0]       ram_raddr;
  logic [hequ_pkg::X_W-1:0]      ram_rdata;
  logic                          cmd_valid;
  hequ_pkg::run_cmd_t            cmd;
  logic                          cmd_pop;
  logic                          run_done;
  hequ_pkg::term_req_t           treq;
  hequ_pkg::term_rsp_t           trsp;
  logic                          div_start;
  logic [hequ_pkg::DVD_W-1:0]    div_dvd;
  logic [hequ_pkg::DVS_W-1:0]    div_dvs;
  logic                          div_done;
  logic [hequ_pkg::DVD_W-1:0]    div_quo;
  logic                          isq_start;
  logic [hequ_pkg::NORM_W-1:0]   norm;
  logic                          isq_done;
  logic [hequ_pkg::ROOT_W-1:0]   isq_root;
  logic [hequ_pkg::X_W-1:0]      out_residual;
  logic [hequ_pkg::AW-1:0]       out_index;
  logic [hequ_pkg::ROOT_W-1:0]   out_norm;

  always_ff @(posedge clk) begin
    if (rst) begin
      points_used <= hequ_pkg::N_W'(64);
      albedo      <= hequ_pkg::OM_W'(58982);
    end else if (cfg_we) begin
      unique case (cfg_index)
        hequ_pkg::CFG_POINTS: points_used <= cfg_data[hequ_pkg::N_W-1:0];
        hequ_pkg::CFG_ALBEDO: albedo      <= cfg_data;
      endcase
    end
  end

  hequ_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .points_used, .albedo,
    .ram_we, .ram_waddr, .ram_wdata, .cmd_valid, .cmd, .cmd_pop, .run_done
  );

  hequ_ram #(.W(hequ_pkg::X_W), .DEPTH(hequ_pkg::MAX_POINTS)) u_store (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  hequ_tdiv u_tdiv (.clk, .rst, .req(treq), .rsp(trsp));

  hequ_sdiv u_sdiv (
    .clk, .rst, .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .done(div_done), .quotient(div_quo)
  );

  hequ_isqrt u_isqrt (
    .clk, .rst, .start(isq_start), .value(norm), .done(isq_done), .root(isq_root)
  );

  hequ_back u_back (
    .clk, .rst, .cmd_valid, .cmd, .cmd_pop, .run_done,
    .ram_re, .ram_raddr, .ram_rdata, .treq, .trsp,
    .div_start, .div_dvd, .div_dvs, .div_done, .div_quo,
    .isq_start, .norm, .isq_done, .isq_root,
    .out_valid(m_tvalid), .out_ready(m_tready), .out_residual, .out_index,
    .out_norm, .out_singular(m_tuser), .out_last(m_tlast)
  );

  assign m_tdata = {2'b00, out_norm, out_index, out_residual};

endmodule

@@ sv/hequ_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module hequ_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/hequ_front.sv @@
// Front end: takes samples, fills the iterate store and queues a run command.
module hequ_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [hequ_pkg::X_W-1:0]        s_tdata,
  input  logic [hequ_pkg::N_W-1:0]        points_used,
  input  logic [hequ_pkg::OM_W-1:0]       albedo,
  output logic                            ram_we,
  output logic [hequ_pkg::AW-1:0]         ram_waddr,
  output logic [hequ_pkg::X_W-1:0]        ram_wdata,
  output logic                            cmd_valid,
  output hequ_pkg::run_cmd_t              cmd,
  input  logic                            cmd_pop,
  input  logic                            run_done
);

  logic [hequ_pkg::CNT_W-1:0] cnt;
  logic [hequ_pkg::CNT_W-1:0] cnt_next;
  logic [hequ_pkg::N_W-1:0]   n_eff;
  logic [hequ_pkg::OM_W-1:0]  om_eff;
  logic                       busy;
  logic                       accept;
  logic                       room;

  always_comb begin
    if (points_used == '0) begin
      n_eff = hequ_pkg::N_W'(1);
    end else if (points_used > hequ_pkg::N_W'(hequ_pkg::MAX_POINTS)) begin
      n_eff = hequ_pkg::N_W'(hequ_pkg::MAX_POINTS);
    end else begin
      n_eff = points_used;
    end
    om_eff = (albedo > hequ_pkg::OM_ONE) ? hequ_pkg::OM_ONE : albedo;
  end

  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;
  assign room      = cnt < hequ_pkg::CNT_W'(hequ_pkg::MAX_POINTS);
  assign cnt_next  = room ? cnt + 1'b1 : cnt;
  assign ram_we    = accept && room;
  assign ram_waddr = cnt[hequ_pkg::AW-1:0];
  assign ram_wdata = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      busy      <= 1'b0;
      cmd_valid <= 1'b0;
    end else begin
      if (cmd_pop) begin
        cmd_valid <= 1'b0;
      end
      if (run_done) begin
        busy <= 1'b0;
      end
      if (accept) begin
        if (cnt_next >= hequ_pkg::CNT_W'(n_eff)) begin
          cnt       <= '0;
          busy      <= 1'b1;
          cmd_valid <= 1'b1;
          cmd.n     <= n_eff;
          cmd.om    <= om_eff;
        end else begin
          cnt <= cnt_next;
        end
      end
    end
  end

endmodule

@@ sv/hequ_tdiv.sv @@
// Pipelined restoring divider for the quadrature terms, one quotient bit per stage.
module hequ_tdiv (
  input  logic                clk,
  input  logic                rst,
  input  hequ_pkg::term_req_t req,
  output hequ_pkg::term_rsp_t rsp
);

  localparam int ST = hequ_pkg::TQ_W;

  logic [ST-1:0]               vld;
  logic [ST-1:0]               neg;
  logic [hequ_pkg::K_W-1:0]    kk  [ST];
  logic [hequ_pkg::K_W-1:0]    rem [ST];
  logic [hequ_pkg::TQ_W-1:0]   dq  [ST];

  function automatic logic [hequ_pkg::K_W+hequ_pkg::TQ_W-1:0] div_step(
    input logic [hequ_pkg::K_W-1:0]  r,
    input logic [hequ_pkg::TQ_W-1:0] d,
    input logic [hequ_pkg::K_W-1:0]  k
  );
    logic [hequ_pkg::K_W:0] rs;
    logic                   ge;
    rs = {r, d[hequ_pkg::TQ_W-1]};
    ge = rs >= {1'b0, k};
    div_step = {ge ? hequ_pkg::K_W'(rs - {1'b0, k}) : hequ_pkg::K_W'(rs),
                d[hequ_pkg::TQ_W-2:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ST-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    {rem[0], dq[0]} <= div_step('0, req.mag, req.k);
    kk[0]  <= req.k;
    neg[0] <= req.neg;
    for (int s = 1; s < ST; s++) begin
      {rem[s], dq[s]} <= div_step(rem[s-1], dq[s-1], kk[s-1]);
      kk[s]  <= kk[s-1];
      neg[s] <= neg[s-1];
    end
  end

  assign rsp.valid = vld[ST-1];
  assign rsp.neg   = neg[ST-1];
  assign rsp.quo   = dq[ST-1];

endmodule

@@ sv/hequ_sdiv.sv @@
// Serial restoring divider, one quotient bit per cycle.
module hequ_sdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [hequ_pkg::DVD_W-1:0]  dividend,
  input  logic [hequ_pkg::DVS_W-1:0]  divisor,
  output logic                        done,
  output logic [hequ_pkg::DVD_W-1:0]  quotient
);

  logic                                 busy;
  logic [$clog2(hequ_pkg::DVD_W)-1:0]   cnt;
  logic [hequ_pkg::DVS_W-1:0]           rem;
  logic [hequ_pkg::DVS_W-1:0]           dvs;
  logic [hequ_pkg::DVD_W-1:0]           dq;
  logic [hequ_pkg::DVS_W:0]             rsh;
  logic                                 ge;

  assign rsh      = {rem, dq[hequ_pkg::DVD_W-1]};
  assign ge       = rsh >= {1'b0, dvs};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(hequ_pkg::DVD_W))'(hequ_pkg::DVD_W - 1);
        rem  <= '0;
        dvs  <= divisor;
        dq   <= dividend;
      end else if (busy) begin
        rem <= ge ? hequ_pkg::DVS_W'(rsh - {1'b0, dvs}) : hequ_pkg::DVS_W'(rsh);
        dq  <= {dq[hequ_pkg::DVD_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/hequ_isqrt.sv @@
// Serial integer square root, two radicand bits per cycle.
module hequ_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [hequ_pkg::NORM_W-1:0]  value,
  output logic                         done,
  output logic [hequ_pkg::ROOT_W-1:0]  root
);

  logic                                busy;
  logic [$clog2(hequ_pkg::ROOT_W)-1:0] cnt;
  logic [hequ_pkg::NORM_W-1:0]         v;
  logic [hequ_pkg::ROOT_W+1:0]         rem;
  logic [hequ_pkg::ROOT_W+3:0]         rsh;
  logic [hequ_pkg::ROOT_W+3:0]         trial;
  logic                                ge;

  assign rsh   = {rem, v[hequ_pkg::NORM_W-1:hequ_pkg::NORM_W-2]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = rsh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ($clog2(hequ_pkg::ROOT_W))'(hequ_pkg::ROOT_W - 1);
        v    <= value;
        rem  <= '0;
        root <= '0;
      end else if (busy) begin
        rem  <= ge ? (hequ_pkg::ROOT_W+2)'(rsh - trial) : (hequ_pkg::ROOT_W+2)'(rsh);
        root <= {root[hequ_pkg::ROOT_W-2:0], ge};
        v    <= {v[hequ_pkg::NORM_W-3:0], 2'b00};
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/hequ_back.sv @@
// Back end: sequences the term sums, divisions, saturation and norm per element.
module hequ_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  hequ_pkg::run_cmd_t            cmd,
  output logic                          cmd_pop,
  output logic                          run_done,
  output logic                          ram_re,
  output logic [hequ_pkg::AW-1:0]       ram_raddr,
  input  logic [hequ_pkg::X_W-1:0]      ram_rdata,
  output hequ_pkg::term_req_t           treq,
  input  hequ_pkg::term_rsp_t           trsp,
  output logic                          div_start,
  output logic [hequ_pkg::DVD_W-1:0]    div_dvd,
  output logic [hequ_pkg::DVS_W-1:0]    div_dvs,
  input  logic                          div_done,
  input  logic [hequ_pkg::DVD_W-1:0]    div_quo,
  output logic                          isq_start,
  output logic [hequ_pkg::NORM_W-1:0]   norm,
  input  logic                          isq_done,
  input  logic [hequ_pkg::ROOT_W-1:0]   isq_root,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hequ_pkg::X_W-1:0]      out_residual,
  output logic [hequ_pkg::AW-1:0]       out_index,
  output logic [hequ_pkg::ROOT_W-1:0]   out_norm,
  output logic                          out_singular,
  output logic                          out_last
);

  typedef enum logic [3:0] {
    B_IDLE, B_ISSUE, B_WAIT, B_XREQ, B_XGET, B_MUL, B_D1GO, B_D1W,
    B_DEN, B_D2W, B_G, B_SQ, B_RGO, B_RW, B_OUT
  } state_t;

  localparam int P_W = hequ_pkg::S_W + hequ_pkg::OM_W + 1;
  localparam int SV_W = hequ_pkg::DVD_W + 1;
  localparam int D_W = hequ_pkg::DVD_W + 2;

  state_t                         st;
  logic [hequ_pkg::N_W-1:0]       n;
  logic [hequ_pkg::OM_W-1:0]      om;
  logic [hequ_pkg::AW-1:0]        i;
  logic [hequ_pkg::AW-1:0]        j;
  logic                           rd_pend;
  logic [hequ_pkg::K_W-1:0]       k_d;
  logic signed [hequ_pkg::S_W-1:0] s_acc;
  logic [hequ_pkg::N_W-1:0]       rcv;
  logic signed [hequ_pkg::X_W-1:0] xi;
  logic signed [P_W-1:0]          p;
  logic                           p_neg;
  logic signed [SV_W-1:0]         s_val;
  logic                           d_neg;
  logic signed [hequ_pkg::X_W-1:0] q;
  logic                           sing;
  logic signed [hequ_pkg::X_W-1:0] g;
  logic [hequ_pkg::ROOT_W-1:0]    root_q;

  logic                           is_last;
  logic                           slot_free;
  logic                           clr;
  logic [hequ_pkg::X_W-1:0]       absx;
  logic [38:0]                    prod;
  logic [hequ_pkg::S_W-1:0]       tmag;
  logic [P_W-1:0]                 pmag;
  logic signed [D_W-1:0]          d_c;
  logic [D_W-1:0]                 dmag;
  logic signed [hequ_pkg::X_W:0]  g_c;
  logic [hequ_pkg::X_W-1:0]       absg;
  logic [2*hequ_pkg::X_W-1:0]     sq;
  logic [hequ_pkg::NORM_W:0]      nsum;

  assign is_last   = {1'b0, i} == n - 1'b1;
  assign slot_free = !out_valid || out_ready;
  assign clr       = (st == B_IDLE && cmd_valid) || (st == B_OUT && slot_free && !is_last);
  assign cmd_pop   = st == B_IDLE && cmd_valid;
  assign ram_re    = st == B_ISSUE || st == B_XREQ;
  assign ram_raddr = (st == B_XREQ) ? i : j;

  always_comb begin
    absx      = ram_rdata[hequ_pkg::X_W-1] ? (~ram_rdata + 1'b1) : ram_rdata;
    prod      = 39'(absx) * 39'({i, 1'b1});
    treq.valid = rd_pend;
    treq.neg   = ram_rdata[hequ_pkg::X_W-1];
    treq.mag   = {prod[37:0], 3'b000};
    treq.k     = k_d;
    tmag      = hequ_pkg::S_W'(trsp.quo);
    pmag      = p[P_W-1] ? P_W'(-p) : P_W'(p);
    d_c       = $signed(D_W'(64'd1 << 28)) - D_W'(s_val);
    dmag      = d_c[D_W-1] ? D_W'(-d_c) : D_W'(d_c);
    g_c       = (hequ_pkg::X_W+1)'(xi) - (hequ_pkg::X_W+1)'(q);
    absg      = g[hequ_pkg::X_W-1] ? hequ_pkg::X_W'(-g) : hequ_pkg::X_W'(g);
    sq        = (2*hequ_pkg::X_W)'(absg) * (2*hequ_pkg::X_W)'(absg);
    nsum      = {1'b0, norm} + (hequ_pkg::NORM_W+1)'(sq);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_acc <= '0;
      rcv   <= '0;
    end else if (clr) begin
      s_acc <= '0;
      rcv   <= '0;
    end else if (trsp.valid) begin
      s_acc <= trsp.neg ? s_acc - $signed(tmag) : s_acc + $signed(tmag);
      rcv   <= rcv + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_IDLE;
      rd_pend   <= 1'b0;
      div_start <= 1'b0;
      isq_start <= 1'b0;
      run_done  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_pend   <= st == B_ISSUE;
      div_start <= 1'b0;
      isq_start <= 1'b0;
      run_done  <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        B_IDLE: begin
          if (cmd_valid) begin
            n    <= cmd.n;
            om   <= cmd.om;
            i    <= '0;
            j    <= '0;
            norm <= '0;
            st   <= B_ISSUE;
          end
        end
        B_ISSUE: begin
          k_d <= hequ_pkg::K_W'(i) + hequ_pkg::K_W'(j) + 1'b1;
          if ({1'b0, j} == n - 1'b1) begin
            st <= B_WAIT;
          end else begin
            j <= j + 1'b1;
          end
        end
        B_WAIT: begin
          if (rcv == n) begin
            st <= B_XREQ;
          end
        end
        B_XREQ: st <= B_XGET;
        B_XGET: begin
          xi <= $signed(ram_rdata);
          st <= B_MUL;
        end
        B_MUL: begin
          p  <= s_acc * $signed({1'b0, om});
          st <= B_D1GO;
        end
        B_D1GO: begin
          p_neg     <= p[P_W-1];
          div_dvd   <= hequ_pkg::DVD_W'(pmag >> 17);
          div_dvs   <= hequ_pkg::DVS_W'(n);
          div_start <= 1'b1;
          st        <= B_D1W;
        end
        B_D1W: begin
          if (div_done) begin
            s_val <= p_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
            st    <= B_DEN;
          end
        end
        B_DEN: begin
          if (d_c == '0) begin
            q    <= $signed({1'b0, {(hequ_pkg::X_W-1){1'b1}}});
            sing <= 1'b1;
            st   <= B_G;
          end else begin
            sing      <= 1'b0;
            d_neg     <= d_c[D_W-1];
            div_dvd   <= hequ_pkg::DVD_W'(64'd1 << 52);
            div_dvs   <= hequ_pkg::DVS_W'(dmag);
            div_start <= 1'b1;
            st        <= B_D2W;
          end
        end
        B_D2W: begin
          if (div_done) begin
            if (!d_neg) begin
              if (div_quo > hequ_pkg::DVD_W'(32'h7FFF_FFFF)) begin
                q    <= $signed({1'b0, {(hequ_pkg::X_W-1){1'b1}}});
                sing <= 1'b1;
              end else begin
                q <= $signed(div_quo[hequ_pkg::X_W-1:0]);
              end
            end else begin
              if (div_quo > hequ_pkg::DVD_W'(33'h0_8000_0000)) begin
                q    <= $signed({1'b1, {(hequ_pkg::X_W-1){1'b0}}});
                sing <= 1'b1;
              end else begin
                q <= -$signed(div_quo[hequ_pkg::X_W-1:0]);
              end
            end
            st <= B_G;
          end
        end
        B_G: begin
          if (g_c[hequ_pkg::X_W] != g_c[hequ_pkg::X_W-1]) begin
            g <= g_c[hequ_pkg::X_W] ? $signed({1'b1, {(hequ_pkg::X_W-1){1'b0}}})
                                    : $signed({1'b0, {(hequ_pkg::X_W-1){1'b1}}});
          end else begin
            g <= g_c[hequ_pkg::X_W-1:0];
          end
          st <= B_SQ;
        end
        B_SQ: begin
          norm <= nsum[hequ_pkg::NORM_W] ? '1 : nsum[hequ_pkg::NORM_W-1:0];
          st   <= is_last ? B_RGO : B_OUT;
        end
        B_RGO: begin
          isq_start <= 1'b1;
          st        <= B_RW;
        end
        B_RW: begin
          if (isq_done) begin
            root_q <= isq_root;
            st     <= B_OUT;
          end
        end
        B_OUT: begin
          if (slot_free) begin
            out_valid    <= 1'b1;
            out_residual <= g;
            out_index    <= i;
            out_norm     <= is_last ? root_q : '0;
            out_singular <= sing;
            out_last     <= is_last;
            if (is_last) begin
              run_done <= 1'b1;
              st       <= B_IDLE;
            end else begin
              i  <= i + 1'b1;
              j  <= '0;
              st <= B_ISSUE;
            end
          end
        end
        default: st <= B_IDLE;
      endcase
    end
  end

endmodule

@@ sv/hequ_checker.sv @@
// Port-level checker for the H-equation residual block, bound to the top level.
module hequ_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic [31:0]                      s_tdata,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [hequ_pkg::TDATA_OUT_W-1:0] m_tdata,
  input logic                             m_tuser,
  input logic                             m_tlast,
  input logic                             cfg_we,
  input logic                             cfg_index,
  input logic [hequ_pkg::OM_W-1:0]        cfg_data
);

  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  a_norm_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[69:38] == '0)
    else $error("norm field nonzero on a non-final word");

  a_no_load_in_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted while a run is in progress");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[71:70] == 2'b00)
    else $error("pad bits of output word set");

endmodule

bind h_equation_residual hequ_checker u_hequ_checker (.*);

@@ dv/h_equation_residual_tb.sv @@
// Self-checking testbench for the H-equation residual block: streams samples, predicts residuals.
module h_equation_residual_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 500000;
  localparam int     DRAIN_CYCLES = 400;

  typedef struct {
    logic [31:0] residual;
    logic [5:0]  index;
    logic [31:0] norm;
    logic        singular;
    logic        last;
  } residual_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [31:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [hequ_pkg::TDATA_OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic cfg_index = hequ_pkg::CFG_POINTS;
  logic [hequ_pkg::OM_W-1:0] cfg_data = '0;

  h_equation_residual u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [31:0]    sample_q[$];
  residual_word_t residual_q[$];
  int             send_idle_pct = 19;
  int             recv_idle_pct = 79;
  int             hold_cycles = 0;
  bit             sample_taken = 0;
  int             mismatches = 0;
  longint         cycles = 0;

  // Shadow of the block's registers and state.
  logic [hequ_pkg::N_W-1:0]  points_sh;
  logic [hequ_pkg::OM_W-1:0] albedo_sh;
  logic signed [31:0]        iterate_sh[hequ_pkg::MAX_POINTS];
  int                        count_sh;

  initial forever #6 clk = ~clk;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip32(longint v, ref bit hit);
    if (v > 64'sd2147483647) begin
      hit = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      hit = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  task automatic predict_residuals(logic signed [31:0] x);
    int n;
    longint om, sum, s, d, q, g;
    longint unsigned sq, acc;
    bit sing, unused;
    residual_word_t w;
    n = int'(points_sh);
    if (n < 1) n = 1;
    if (n > hequ_pkg::MAX_POINTS) n = hequ_pkg::MAX_POINTS;
    om = (albedo_sh > hequ_pkg::OM_ONE) ? 64'sd65536 : longint'(albedo_sh);
    if (count_sh < hequ_pkg::MAX_POINTS) begin
      iterate_sh[count_sh] = x;
      count_sh++;
    end
    if (count_sh < n) return;
    acc = 0;
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int j = 0; j < n; j++)
        sum += (longint'(iterate_sh[j]) * (2 * i + 1) * 16) / (2 * (i + j + 1));
      s = (sum * om) / (longint'(n) * 131072);
      d = (64'sd1 <<< 28) - s;
      sing = 0;
      unused = 0;
      if (d == 0) begin
        q = 64'sd2147483647;
        sing = 1;
      end else begin
        q = clip32((64'sd1 <<< 52) / d, sing);
      end
      g = clip32(longint'(iterate_sh[i]) - q, unused);
      sq = (g < 0) ? -g : g;
      sq = sq * sq;
      acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
      w.residual = g[31:0];
      w.index = i[5:0];
      w.singular = sing;
      w.last = (i + 1 == n);
      w.norm = w.last ? 32'(root64(acc)) : 32'd0;
      residual_q.push_back(w);
    end
    count_sh = 0;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
    sample_taken = !rst && s_tvalid && s_tready;
    if (rst) begin
      points_sh = 7'd64;
      albedo_sh = 17'd58982;
      count_sh = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == hequ_pkg::CFG_POINTS) points_sh = cfg_data[hequ_pkg::N_W-1:0];
        else albedo_sh = cfg_data;
      end
      if (sample_taken) predict_residuals(s_tdata);
      if (m_tvalid && m_tready) begin
        if (residual_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected word: %h", m_tdata);
        end else begin
          residual_word_t e;
          e = residual_q.pop_front();
          if (m_tdata[31:0] !== e.residual || m_tdata[37:32] !== e.index ||
              m_tdata[69:38] !== e.norm || m_tuser !== e.singular ||
              m_tlast !== e.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"Mismatch: exp res=%h idx=%0d norm=%h sing=%b last=%b, ",
                        "got res=%h idx=%0d norm=%h sing=%b last=%b"},
                       e.residual, e.index, e.norm, e.singular, e.last, m_tdata[31:0],
                       m_tdata[37:32], m_tdata[69:38], m_tuser, m_tlast);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || sample_taken)) begin
      if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= sample_q.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= !rst && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_idle();
    while (sample_q.size() > 0 || s_tvalid || residual_q.size() > 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [hequ_pkg::OM_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] rand_sample();
    if ($urandom_range(2) == 0) return $urandom();
    return 32'h0100_0000 + $urandom_range(32'h0040_0000) - 32'h0020_0000;
  endfunction

  initial begin
    int n, runs, phases;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Points above the maximum act as the maximum; albedo keeps its reset value.
    write_reg(hequ_pkg::CFG_POINTS, 17'd127);
    for (int k = 0; k < 64; k++) sample_q.push_back(32'h0100_0000 + k * 32'h1000);
    wait_idle();

    write_reg(hequ_pkg::CFG_POINTS, 17'd1);
    write_reg(hequ_pkg::CFG_ALBEDO, 17'd0);
    sample_q.push_back(32'h8000_0000);
    sample_q.push_back(32'h7FFF_FFFF);
    sample_q.push_back(32'h0000_0000);
    sample_q.push_back(32'hFFFF_FFFF);
    wait_idle();
    // With full albedo, a single sample of 4.0 makes the denominator vanish.
    write_reg(hequ_pkg::CFG_ALBEDO, 17'd65536);
    sample_q.push_back(32'h0400_0000);
    sample_q.push_back(32'h03FF_FFFF);
    sample_q.push_back(32'h0400_0001);
    wait_idle();
    write_reg(hequ_pkg::CFG_ALBEDO, 17'h1FFFF);
    write_reg(hequ_pkg::CFG_POINTS, 17'h1FF80);
    sample_q.push_back(32'h0400_0000);
    sample_q.push_back(32'h0100_0000);
    wait_idle();
    // Points lowered while a load is in progress.
    write_reg(hequ_pkg::CFG_ALBEDO, 17'd32768);
    write_reg(hequ_pkg::CFG_POINTS, 17'd8);
    repeat (5) sample_q.push_back(rand_sample());
    wait_idle();
    write_reg(hequ_pkg::CFG_POINTS, 17'd3);
    sample_q.push_back(rand_sample());
    wait_idle();

    phases = 6;
    for (int p = 0; p < phases; p++) begin
      case (p * 3 / phases)
        0: begin send_idle_pct = 19; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 19; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      n = $urandom_range(8, 1);
      write_reg(hequ_pkg::CFG_POINTS, 17'(n));
      case ($urandom_range(3))
        0: write_reg(hequ_pkg::CFG_ALBEDO, 17'd65536);
        1: write_reg(hequ_pkg::CFG_ALBEDO, 17'd0);
        default: write_reg(hequ_pkg::CFG_ALBEDO, 17'($urandom_range(65536)));
      endcase
      runs = $urandom_range(2, 1);
      if (p == 4) begin
        hold_cycles = 3000;
        runs = 2;
      end
      for (int r = 0; r < runs * n; r++) sample_q.push_back(rand_sample());
      wait_idle();
    end

    while (residual_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
